[rtl/aarm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package aarm_pkg;

	// One input beat: axis in Q4.12, angle in Q10.6 degrees.
	typedef struct packed {
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic signed [15:0] angle_deg;
	} aarm_in_t;

	// One output beat: matrix in Q1.14, row then column.
	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
		logic               axis_zero;
	} aarm_out_t;

	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

endpackage
`default_nettype wire

[rtl/aarm_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface aarm_in_if import aarm_pkg::*; ();
	logic      valid;
	logic      ready;
	aarm_in_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aarm_out_if import aarm_pkg::*; ();
	logic      valid;
	logic      ready;
	aarm_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/axis_angle_rotation_matrix_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Axis-angle to 3x3 rotation matrix, fully pipelined.
// Channels: axis_angle (sink) takes one beat of axis_x/y/z (Q4.12) and angle_deg
// (Q10.6 degrees, counter-clockwise positive); matrix (source) gives one beat of
// the nine entries m00..m22 (Q1.14) and axis_zero. Every input beat gives exactly
// one output beat, in order.
// Each beat passes through 30 register stages, the first loaded at the accepting
// edge and the last being the output register, where the result sits with valid
// high.
// Throughput: one beat per cycle unless stalled. The slowest part is the 16-stage
// bit-per-stage loop that forms the six normalized axis products (restoring
// division) and the three cross terms (rounded square-root search), one quotient
// bit per stage. Sine and cosine come from a Taylor series over stages 3 to 9 of
// 30x30 products. A zero axis gives the identity and axis_zero set.
// Reset: arst_n clears all stage valid bits at once; data registers are not reset.
// Stall: when matrix.ready is low with a result waiting, the whole pipeline holds
// and axis_angle.ready drops; nothing is lost or repeated. With the output register
// empty the pipeline keeps advancing and fills bubbles.
module axis_angle_rotation_matrix_top import aarm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	aarm_in_if.sink    axis_angle,
	aarm_out_if.source matrix
);

	localparam int NSTG = 30;

	// Reciprocal multipliers for exact floor division of 30-bit values.
	localparam logic [30:0] M6     = 31'(((64'd1 << 33) + 64'd5) / 64'd6);
	localparam logic [30:0] M24    = 31'(((64'd1 << 35) + 64'd23) / 64'd24);
	localparam logic [30:0] M120   = 31'(((64'd1 << 37) + 64'd119) / 64'd120);
	localparam logic [30:0] M720   = 31'(((64'd1 << 40) + 64'd719) / 64'd720);
	localparam logic [30:0] M5040  = 31'(((64'd1 << 43) + 64'd5039) / 64'd5040);
	localparam logic [30:0] M40320 = 31'(((64'd1 << 46) + 64'd40319) / 64'd40320);

	typedef struct packed {
		logic [2:0][30:0] sq;   // squared component magnitudes
		logic [2:0][30:0] pr;   // yz, xz, xy magnitude products
		logic [2:0]       neg;
		logic [31:0]      n2;
		logic             zero;
	} ax_t;

	typedef struct packed {
		logic [1:0] q;
		logic       swp;
	} qd_t;

	typedef struct packed {
		logic [5:0][46:0] rem;  // division remainders
		logic [5:0][15:0] qt;   // quotients: diag x,y,z then yz,xz,xy
		logic [2:0][61:0] rr;   // cross search residue, signed
		logic [2:0][49:0] aa;   // (2*lo-1)*n2, signed
		logic [2:0][15:0] lo;   // cross term magnitudes
		logic [32:0]      dv;   // 2*n2
		logic [31:0]      n2;
		logic [2:0]       neg;
		logic             sneg;
		logic [15:0]      c;
		logic             zero;
	} lp_t;

	function automatic logic [29:0] pq30(input logic [29:0] a, input logic [29:0] b);
		logic [59:0] t;
		t = 60'(a) * 60'(b) + (60'd1 << 29);
		return t[59:30];
	endfunction

	function automatic logic [29:0] mulsh(input logic [29:0] v, input logic [30:0] m,
		input int sh);
		logic [60:0] t;
		t = 61'(v) * 61'(m);
		return 30'(t >> sh);
	endfunction

	function automatic logic signed [17:0] sgn(input logic [15:0] mg, input logic neg);
		logic signed [17:0] t;
		t = $signed({2'b00, mg});
		return neg ? -t : t;
	endfunction

	function automatic logic signed [15:0] sat(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd16384) begin
			r = ONE_Q14;
		end else if (v < -18'sd16384) begin
			r = -ONE_Q14;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	logic            en;
	logic [NSTG:1]   vld_s;

	// stage 1
	logic [2:0][15:0] vin, mag;
	logic [16:0]      a0;
	logic [14:0]      a1;
	logic [14:0]      a_s1;
	ax_t              ax_s [1:12];
	// stage 2
	ax_t              ax2;
	logic [12:0]      rem2;
	qd_t              qd2;
	logic [11:0]      r2;
	logic [11:0]      r_s2;
	qd_t              qd_s [2:9];
	// sine/cosine series
	logic [29:0] x_s3;
	logic [29:0] x_s4, x2_s4;
	logic [29:0] x_s5, x2_s5, x3_s5, x4_s5;
	logic [29:0] x_s6, x4_s6, x5_s6, x6_s6, x8_s6, d3_s6, d2_s6;
	logic [29:0] x_s7, x7_s7, d2_s7, d3_s7, d4_s7, d5_s7, d6_s7, d8_s7;
	logic [29:0] x_s8, d2_s8, d3_s8, d4_s8, d5_s8, d6_s8, d7_s8, d8_s8;
	logic [31:0] sv9, cv9;
	logic [14:0] sb_s9, cb_s9;
	logic [14:0] s0_10, c0_10;
	logic signed [15:0] s10, c10;
	logic signed [15:0] s_s10, c_s10;
	// pre-loop
	logic [15:0] sabs11;
	logic [15:0] omc_s11, c_s11;
	logic [28:0] ssq_s11;
	logic        sneg_s11, sneg_s12;
	logic [15:0] c_s12;
	logic [5:0][45:0] m_s12;
	logic [2:0][60:0] t_s12;
	// loop
	lp_t lp13;
	lp_t lp_s [13:29];
	lp_t lp_nxt [16];
	// output
	logic signed [17:0] dg [3];
	logic signed [17:0] kk [3];
	logic signed [17:0] ox, oy, oz;
	aarm_out_t res;
	aarm_out_t out_s30;

	// Advance everything together unless a result is waiting on a stalled sink.
	assign en = !vld_s[NSTG] || matrix.ready;
	assign axis_angle.ready = en;
	assign matrix.valid = vld_s[NSTG];
	assign matrix.data = out_s30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NSTG-1:1], axis_angle.valid};
		end
	end

	// Stage 1: magnitudes and angle wrap into one turn.
	always_comb begin
		vin[0] = axis_angle.data.axis_x;
		vin[1] = axis_angle.data.axis_y;
		vin[2] = axis_angle.data.axis_z;
		for (int i = 0; i < 3; i++) begin
			mag[i] = vin[i][15] ? 16'(-vin[i]) : vin[i];
		end
		a0 = 17'(18'(axis_angle.data.angle_deg) + 18'sd46080);
		if (a0 >= 17'd69120) begin
			a1 = 15'(a0 - 17'd69120);
		end else if (a0 >= 17'd46080) begin
			a1 = 15'(a0 - 17'd46080);
		end else if (a0 >= 17'd23040) begin
			a1 = 15'(a0 - 17'd23040);
		end else begin
			a1 = 15'(a0);
		end
	end

	// Stage 2: axis length squared, quadrant and folded remainder.
	always_comb begin
		ax2 = ax_s[1];
		ax2.n2 = 32'(ax_s[1].sq[0]) + 32'(ax_s[1].sq[1]) + 32'(ax_s[1].sq[2]);
		ax2.zero = (ax2.n2 == 32'd0);
		if (a_s1 >= 15'd17280) begin
			qd2.q = 2'd3;
			rem2 = 13'(a_s1 - 15'd17280);
		end else if (a_s1 >= 15'd11520) begin
			qd2.q = 2'd2;
			rem2 = 13'(a_s1 - 15'd11520);
		end else if (a_s1 >= 15'd5760) begin
			qd2.q = 2'd1;
			rem2 = 13'(a_s1 - 15'd5760);
		end else begin
			qd2.q = 2'd0;
			rem2 = 13'(a_s1);
		end
		qd2.swp = (rem2 > 13'd2880);
		r2 = qd2.swp ? 12'(13'd5760 - rem2) : 12'(rem2);
	end

	// Stage 9/10: series sums, rounding to Q1.14, octant swap and quadrant map.
	always_comb begin
		sv9 = 32'(x_s8) - 32'(d3_s8) + 32'(d5_s8) - 32'(d7_s8);
		cv9 = (32'd1 << 30) - 32'(d2_s8) + 32'(d4_s8) - 32'(d6_s8) + 32'(d8_s8);
		s0_10 = qd_s[9].swp ? cb_s9 : sb_s9;
		c0_10 = qd_s[9].swp ? sb_s9 : cb_s9;
		case (qd_s[9].q)
			2'd0: begin
				s10 = $signed({1'b0, s0_10});
				c10 = $signed({1'b0, c0_10});
			end
			2'd1: begin
				s10 = $signed({1'b0, c0_10});
				c10 = -$signed({1'b0, s0_10});
			end
			2'd2: begin
				s10 = -$signed({1'b0, s0_10});
				c10 = -$signed({1'b0, c0_10});
			end
			default: begin
				s10 = -$signed({1'b0, c0_10});
				c10 = $signed({1'b0, s0_10});
			end
		endcase
		sabs11 = s_s10[15] ? 16'(-s_s10) : $unsigned(s_s10);
	end

	// Stage 13: set up dividers (2m+n2)/(2n2) and cross searches.
	always_comb begin
		lp13 = '0;
		for (int k = 0; k < 6; k++) begin
			lp13.rem[k] = 47'({m_s12[k], 1'b0}) + 47'(ax_s[12].n2);
		end
		for (int k = 0; k < 3; k++) begin
			lp13.rr[k] = 62'(t_s12[k]) - 62'(ax_s[12].n2);
			lp13.aa[k] = 50'd0 - 50'(ax_s[12].n2);
		end
		lp13.dv = {ax_s[12].n2, 1'b0};
		lp13.n2 = ax_s[12].n2;
		lp13.neg = ax_s[12].neg;
		lp13.zero = ax_s[12].zero;
		lp13.sneg = sneg_s12;
		lp13.c = c_s12;
	end

	// Bit loop: one quotient bit and one cross-term bit per stage, MSB first.
	always_comb begin
		logic [48:0]        dt;
		logic signed [71:0] dl;
		logic signed [71:0] tr;
		for (int g = 0; g < 16; g++) begin
			lp_nxt[g] = lp_s[13+g];
			for (int k = 0; k < 6; k++) begin
				dt = 49'(lp_s[13+g].rem[k]) - (49'(lp_s[13+g].dv) << (15 - g));
				if (!dt[48]) begin
					lp_nxt[g].rem[k] = dt[46:0];
					lp_nxt[g].qt[k][4'(15 - g)] = 1'b1;
				end
			end
			for (int k = 0; k < 3; k++) begin
				dl = (72'($signed(lp_s[13+g].aa[k])) <<< (17 - g))
					+ $signed(72'(lp_s[13+g].n2) << (32 - 2 * g));
				tr = 72'($signed(lp_s[13+g].rr[k])) - dl;
				if (!tr[71]) begin
					lp_nxt[g].rr[k] = tr[61:0];
					lp_nxt[g].aa[k] = lp_s[13+g].aa[k] + (50'(lp_s[13+g].n2) << (16 - g));
					lp_nxt[g].lo[k][4'(15 - g)] = 1'b1;
				end
			end
		end
	end

	// Final: assemble entries, saturate, override for a zero axis.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dg[k] = 18'($signed(lp_s[29].c)) + sgn(lp_s[29].qt[k], 1'b0);
			kk[k] = sgn(lp_s[29].lo[k], lp_s[29].sneg ^ lp_s[29].neg[k]);
		end
		ox = sgn(lp_s[29].qt[3], lp_s[29].neg[1] ^ lp_s[29].neg[2]);
		oy = sgn(lp_s[29].qt[4], lp_s[29].neg[0] ^ lp_s[29].neg[2]);
		oz = sgn(lp_s[29].qt[5], lp_s[29].neg[0] ^ lp_s[29].neg[1]);
		res.m00 = sat(dg[0]);
		res.m01 = sat(oz - kk[2]);
		res.m02 = sat(oy + kk[1]);
		res.m10 = sat(oz + kk[2]);
		res.m11 = sat(dg[1]);
		res.m12 = sat(ox - kk[0]);
		res.m20 = sat(oy - kk[1]);
		res.m21 = sat(ox + kk[0]);
		res.m22 = sat(dg[2]);
		res.axis_zero = 1'b0;
		if (lp_s[29].zero) begin
			res = '0;
			res.m00 = ONE_Q14;
			res.m11 = ONE_Q14;
			res.m22 = ONE_Q14;
			res.axis_zero = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			a_s1 <= a1;
			for (int i = 0; i < 3; i++) begin
				ax_s[1].sq[i] <= 31'(32'(mag[i]) * 32'(mag[i]));
				ax_s[1].neg[i] <= vin[i][15];
			end
			ax_s[1].pr[0] <= 31'(32'(mag[1]) * 32'(mag[2]));
			ax_s[1].pr[1] <= 31'(32'(mag[0]) * 32'(mag[2]));
			ax_s[1].pr[2] <= 31'(32'(mag[0]) * 32'(mag[1]));
			ax_s[1].n2 <= '0;
			ax_s[1].zero <= 1'b0;
			// stage 2
			ax_s[2] <= ax2;
			r_s2 <= r2;
			qd_s[2] <= qd2;
			for (int i = 3; i <= 12; i++) begin
				ax_s[i] <= ax_s[i-1];
			end
			for (int i = 3; i <= 9; i++) begin
				qd_s[i] <= qd_s[i-1];
			end
			// stage 3: angle in radians, Q30
			x_s3 <= 30'(31'(r_s2) * 31'd292818);
			// stage 4
			x_s4 <= x_s3;
			x2_s4 <= pq30(x_s3, x_s3);
			// stage 5
			x_s5 <= x_s4;
			x2_s5 <= x2_s4;
			x3_s5 <= pq30(x2_s4, x_s4);
			x4_s5 <= pq30(x2_s4, x2_s4);
			// stage 6
			x_s6 <= x_s5;
			x4_s6 <= x4_s5;
			x5_s6 <= pq30(x4_s5, x_s5);
			x6_s6 <= pq30(x4_s5, x2_s5);
			x8_s6 <= pq30(x4_s5, x4_s5);
			d3_s6 <= mulsh(x3_s5, M6, 33);
			d2_s6 <= x2_s5 >> 1;
			// stage 7
			x_s7 <= x_s6;
			x7_s7 <= pq30(x6_s6, x_s6);
			d2_s7 <= d2_s6;
			d3_s7 <= d3_s6;
			d4_s7 <= mulsh(x4_s6, M24, 35);
			d5_s7 <= mulsh(x5_s6, M120, 37);
			d6_s7 <= mulsh(x6_s6, M720, 40);
			d8_s7 <= mulsh(x8_s6, M40320, 46);
			// stage 8
			x_s8 <= x_s7;
			d2_s8 <= d2_s7;
			d3_s8 <= d3_s7;
			d4_s8 <= d4_s7;
			d5_s8 <= d5_s7;
			d6_s8 <= d6_s7;
			d7_s8 <= mulsh(x7_s7, M5040, 43);
			d8_s8 <= d8_s7;
			// stage 9
			sb_s9 <= 15'((sv9 + 32'd32768) >> 16);
			cb_s9 <= 15'((cv9 + 32'd32768) >> 16);
			// stage 10
			s_s10 <= s10;
			c_s10 <= c10;
			// stage 11
			omc_s11 <= 16'd16384 - $unsigned(c_s10);
			ssq_s11 <= 29'(30'(sabs11) * 30'(sabs11));
			sneg_s11 <= s_s10[15];
			c_s11 <= $unsigned(c_s10);
			// stage 12
			for (int k = 0; k < 3; k++) begin
				m_s12[k] <= 46'(47'(omc_s11) * 47'(ax_s[11].sq[k]));
				m_s12[k+3] <= 46'(47'(omc_s11) * 47'(ax_s[11].pr[k]));
				t_s12[k] <= 61'((62'(ssq_s11) * 62'(ax_s[11].sq[k])) << 2);
			end
			sneg_s12 <= sneg_s11;
			c_s12 <= c_s11;
			// stage 13 and loop
			lp_s[13] <= lp13;
			for (int g = 0; g < 16; g++) begin
				lp_s[14+g] <= lp_nxt[g];
			end
			// output register
			out_s30 <= res;
		end
	end

`ifndef NO_ASSERTIONS
	// Input is refused only while a finished beat waits on a stalled sink.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!axis_angle.ready |-> matrix.valid && !matrix.ready)
		else $error("input stalled without an output stall");

	// An advancing pipeline loads the first stage valid from the input.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(en) |-> vld_s[1] == $past(axis_angle.valid))
		else $error("first stage valid lost or invented");

	// A zero axis beat carries ones on the diagonal and zeros in m01, m12 and m20.
	a_zero_ident: assert property (@(posedge clk) disable iff (!arst_n)
		matrix.valid && matrix.data.axis_zero |->
		matrix.data.m00 == ONE_Q14 && matrix.data.m11 == ONE_Q14 &&
		matrix.data.m22 == ONE_Q14 && matrix.data.m01 == 16'sd0 &&
		matrix.data.m12 == 16'sd0 && matrix.data.m20 == 16'sd0)
		else $error("zero axis beat is not the identity");
`endif

endmodule
`default_nettype wire
